FILE: sv/ppu_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the particle pool update block.
// Used by the controller, the datapath and the top level; depends on nothing.
package ppu_pkg;

  localparam int QW = 20;
  localparam int VW = 60;
  localparam int AGEW = 10;
  localparam int SCW = 16;
  localparam int COLW = 32;
  localparam int LANES = 5;
  localparam int PRODW = 26;
  localparam int IN_DW = 288;
  localparam int OUT_DW = 112;

  localparam logic [1:0] IN_ADD = 2'd0;
  localparam logic [1:0] IN_TICK = 2'd1;
  localparam logic [1:0] IN_CLEAR = 2'd2;
  localparam logic [1:0] IN_UNUSED = 2'd3;

  localparam logic [2:0] RES_VERTEX = 3'd0;
  localparam logic [2:0] RES_ADDED = 3'd1;
  localparam logic [2:0] RES_DROPPED = 3'd2;
  localparam logic [2:0] RES_CLEARED = 3'd3;
  localparam logic [2:0] RES_EMPTY = 3'd4;

  typedef struct packed {
    logic [COLW-1:0] death_color;
    logic [COLW-1:0] birth_color;
    logic [SCW-1:0]  death_scale;
    logic [SCW-1:0]  birth_scale;
    logic [AGEW-1:0] life;
    logic [AGEW-1:0] age;
    logic [VW-1:0]   acc;
    logic [VW-1:0]   vel;
    logic [VW-1:0]   pos;
  } particle_t;

  typedef struct packed {
    logic       latch_in;
    logic       add_wr;
    logic       clr;
    logic       rd_a;
    logic       vel;
    logic       wr_a;
    logic       a_done;
    logic       rd_b;
    logic       mul;
    logic       div_go;
    logic       emit_kind;
    logic       emit_vtx;
    logic [2:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic a_end;
    logic i_zero;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/ppu_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Uses ppu_pkg for widths.
module ppu_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ppu_pkg::PRODW-1:0] dividend,
  input  logic [ppu_pkg::AGEW-1:0]  divisor,
  output logic                      busy,
  output logic [ppu_pkg::PRODW-1:0] quotient
);
  localparam int CNTW = $clog2(ppu_pkg::PRODW + 1);

  logic [ppu_pkg::AGEW-1:0]  rem_r;
  logic [ppu_pkg::AGEW-1:0]  div_r;
  logic [ppu_pkg::PRODW-1:0] quo_r;
  logic [CNTW-1:0]           cnt_r;
  logic                      busy_r;
  logic [ppu_pkg::AGEW:0]    trial;
  logic [ppu_pkg::AGEW:0]    diff;

  assign trial = {rem_r, quo_r[ppu_pkg::PRODW-1]};
  assign diff = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CNTW'(ppu_pkg::PRODW);
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_r <= diff[ppu_pkg::AGEW-1:0];
        quo_r <= {quo_r[ppu_pkg::PRODW-2:0], 1'b1};
      end else begin
        rem_r <= trial[ppu_pkg::AGEW-1:0];
        quo_r <= {quo_r[ppu_pkg::PRODW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quotient = quo_r;
endmodule

FILE: sv/ppu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for add, clear and the two passes of a tick.
// Uses ppu_pkg for the command and status structs.
module ppu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  input  ppu_pkg::sts_t     sts,
  output logic              in_ready,
  output ppu_pkg::cmd_t     cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_CLR, S_A_RD, S_A_VEL, S_A_WR, S_B_CHK,
    S_B_RD, S_B_MUL, S_B_DIV, S_B_WAIT, S_B_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_kind)
            ppu_pkg::IN_ADD:   state_nxt = S_ADD;
            ppu_pkg::IN_TICK:  state_nxt = S_A_RD;
            ppu_pkg::IN_CLEAR: state_nxt = S_CLR;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.emit_kind = 1'b1;
          if (sts.full) begin
            cmd.res_kind = ppu_pkg::RES_DROPPED;
          end else begin
            cmd.add_wr = 1'b1;
            cmd.res_kind = ppu_pkg::RES_ADDED;
          end
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        if (sts.out_free) begin
          cmd.clr = 1'b1;
          cmd.emit_kind = 1'b1;
          cmd.res_kind = ppu_pkg::RES_CLEARED;
          state_nxt = S_IDLE;
        end
      end
      S_A_RD: begin
        if (sts.a_end) begin
          cmd.a_done = 1'b1;
          state_nxt = S_B_CHK;
        end else begin
          cmd.rd_a = 1'b1;
          state_nxt = S_A_VEL;
        end
      end
      S_A_VEL: begin
        cmd.vel = 1'b1;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        cmd.wr_a = 1'b1;
        state_nxt = S_A_RD;
      end
      S_B_CHK: begin
        if (!sts.cnt_zero) begin
          state_nxt = S_B_RD;
        end else if (sts.out_free) begin
          cmd.emit_kind = 1'b1;
          cmd.res_kind = ppu_pkg::RES_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_B_RD: begin
        cmd.rd_b = 1'b1;
        state_nxt = S_B_MUL;
      end
      S_B_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_B_DIV;
      end
      S_B_DIV: begin
        cmd.div_go = 1'b1;
        state_nxt = S_B_WAIT;
      end
      S_B_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = S_B_EMIT;
        end
      end
      S_B_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_vtx = 1'b1;
          state_nxt = sts.i_zero ? S_IDLE : S_B_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
endmodule

FILE: sv/ppu_dp.sv
`timescale 1ns / 1ps
// Particle memory, counters, integration, interpolation lanes and output register.
// Uses ppu_pkg and ppu_div.
module ppu_dp #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ppu_pkg::cmd_t               cmd,
  input  logic [ppu_pkg::IN_DW-1:0]   in_data,
  input  logic                        out_ready,
  output ppu_pkg::sts_t               sts,
  output logic                        out_valid,
  output logic [2:0]                  out_kind,
  output logic [ppu_pkg::OUT_DW-1:0]  out_data,
  output logic                        out_last
);
  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int QW = ppu_pkg::QW;

  ppu_pkg::particle_t mem [MAX_PARTICLES];
  ppu_pkg::particle_t mem_q_r;
  ppu_pkg::particle_t in_r;
  ppu_pkg::particle_t upd;

  logic [CW-1:0] count_r, r_r, w_r;
  logic [AW-1:0] i_r;
  logic [ppu_pkg::VW-1:0] nv_r, nv, np;
  logic alive;

  logic [ppu_pkg::SCW-1:0]   base_r [ppu_pkg::LANES];
  logic                      neg_r  [ppu_pkg::LANES];
  logic [ppu_pkg::PRODW-1:0] prod_r [ppu_pkg::LANES];
  logic [ppu_pkg::PRODW-1:0] quo    [ppu_pkg::LANES];
  logic [ppu_pkg::SCW-1:0]   res    [ppu_pkg::LANES];
  logic [ppu_pkg::SCW-1:0]   ls     [ppu_pkg::LANES];
  logic [ppu_pkg::SCW-1:0]   le     [ppu_pkg::LANES];
  logic                      busy   [ppu_pkg::LANES];
  logic [ppu_pkg::AGEW-1:0]  life_r;

  logic                      out_valid_r, out_last_r;
  logic [2:0]                out_kind_r;
  logic [ppu_pkg::OUT_DW-1:0] out_data_r;

  function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      sat_add = s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      sat_add = s[QW-1:0];
    end
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nv[k*QW +: QW] = sat_add(mem_q_r.vel[k*QW +: QW], mem_q_r.acc[k*QW +: QW]);
      np[k*QW +: QW] = sat_add(mem_q_r.pos[k*QW +: QW], nv_r[k*QW +: QW]);
    end
    alive = mem_q_r.age < mem_q_r.life;
    upd = mem_q_r;
    upd.age = mem_q_r.age + 1'b1;
    upd.vel = nv_r;
    upd.pos = np;
  end

  always_comb begin
    ls[0] = mem_q_r.birth_scale;
    le[0] = mem_q_r.death_scale;
    for (int k = 1; k < ppu_pkg::LANES; k++) begin
      ls[k] = {8'd0, mem_q_r.birth_color[(k-1)*8 +: 8]};
      le[k] = {8'd0, mem_q_r.death_color[(k-1)*8 +: 8]};
    end
    for (int k = 0; k < ppu_pkg::LANES; k++) begin
      res[k] = neg_r[k] ? base_r[k] - quo[k][ppu_pkg::SCW-1:0]
                        : base_r[k] + quo[k][ppu_pkg::SCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r.pos <= in_data[69:10];
      in_r.vel <= in_data[129:70];
      in_r.acc <= in_data[189:130];
      in_r.life <= in_data[9:0];
      in_r.age <= '0;
      in_r.birth_scale <= in_data[205:190];
      in_r.death_scale <= in_data[221:206];
      in_r.birth_color <= in_data[253:222];
      in_r.death_color <= in_data[285:254];
    end
    if (cmd.add_wr) begin
      mem[count_r[AW-1:0]] <= in_r;
    end else if (cmd.wr_a && alive) begin
      mem[w_r[AW-1:0]] <= upd;
    end
    if (cmd.rd_a) begin
      mem_q_r <= mem[r_r[AW-1:0]];
    end else if (cmd.rd_b) begin
      mem_q_r <= mem[i_r];
    end
    if (cmd.vel) begin
      nv_r <= nv;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ppu_pkg::SCW:0] d;
    logic [ppu_pkg::SCW-1:0] mag;
    if (cmd.mul) begin
      life_r <= mem_q_r.life;
      for (int k = 0; k < ppu_pkg::LANES; k++) begin
        d = $signed({1'b0, le[k]}) - $signed({1'b0, ls[k]});
        mag = d[ppu_pkg::SCW] ? ppu_pkg::SCW'(-d) : d[ppu_pkg::SCW-1:0];
        neg_r[k] <= d[ppu_pkg::SCW];
        base_r[k] <= ls[k];
        prod_r[k] <= ppu_pkg::PRODW'(mag) * ppu_pkg::PRODW'(mem_q_r.age);
      end
    end
  end

  for (genvar g = 0; g < ppu_pkg::LANES; g++) begin : g_lane
    ppu_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_go),
      .dividend (prod_r[g]),
      .divisor  (life_r),
      .busy     (busy[g]),
      .quotient (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      r_r <= '0;
      w_r <= '0;
      i_r <= '0;
    end else begin
      if (cmd.latch_in) begin
        r_r <= '0;
        w_r <= '0;
      end
      if (cmd.add_wr) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.clr) begin
        count_r <= '0;
      end
      if (cmd.wr_a) begin
        r_r <= r_r + 1'b1;
        if (alive) begin
          w_r <= w_r + 1'b1;
        end
      end
      if (cmd.a_done) begin
        count_r <= w_r;
        i_r <= AW'(w_r - 1'b1);
      end
      if (cmd.emit_vtx) begin
        i_r <= i_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_kind || cmd.emit_vtx) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit_kind) begin
      out_kind_r <= cmd.res_kind;
      out_data_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.emit_vtx) begin
      out_kind_r <= ppu_pkg::RES_VERTEX;
      out_data_r <= {4'd0, res[4][7:0], res[3][7:0], res[2][7:0], res[1][7:0],
                     res[0], mem_q_r.pos};
      out_last_r <= (i_r == '0);
    end
  end

  assign sts.full = (count_r == CW'(MAX_PARTICLES));
  assign sts.cnt_zero = (count_r == '0);
  assign sts.a_end = (r_r == count_r);
  assign sts.i_zero = (i_r == '0);
  assign sts.div_busy = busy[0];
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_data = out_data_r;
  assign out_last = out_last_r;
endmodule

FILE: sv/particle_pool_update.sv
`timescale 1ns / 1ps
// Top level of the particle pool: controller, datapath and port packing.
// Depends on ppu_pkg, ppu_ctrl, ppu_dp and ppu_div.
//
// Channel   Ports                  Contents
// input     in_tvalid/tready/...   tuser kind; tdata particle spawn record
// result    out_tvalid/tready/...  tuser result kind; tdata vertex; tlast
//
// Add and clear latch the item and load their result once the output is free.
// A tick first runs the integration pass over the pool, then an interpolation pass
// for each surviving particle, which waits on the 26-step dividers.
// Reset empties the pool at once; no clearing pass is needed.
// A stalled result holds the block; a new item is taken once the last result is loaded.
module particle_pool_update #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // life, spawn_position, spawn_velocity, spawn_acceleration, scale at birth,
  // scale at end of life, color at birth, color at end of life
  input  logic [287:0] in_tdata,
  // kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_position, vertex_scale, vertex_color
  output logic [111:0] out_tdata,
  // result_kind
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);
  ppu_pkg::cmd_t cmd;
  ppu_pkg::sts_t sts;

  ppu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  ppu_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != ppu_pkg::IN_UNUSED) |=> !in_tready)
    else $error("block took an item while still working");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ppu_pkg::RES_EMPTY)
    else $error("result kind out of range");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ppu_pkg::RES_VERTEX) |-> out_tlast && (out_tdata == '0))
    else $error("status result with data or without last");
endmodule
